FILE: hw/rtl/skf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg: shared definitions of the three-channel scalar kalman filter
// defaults of the data format, register indexes and register reset values
// ----------------------------------------------------------------------------
package skf_pkg;

    // default data format: signed word of DATA_WIDTH bits, FRAC_BITS fraction
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MEAS_NOISE_X  = 3'd0,
        REG_MEAS_NOISE_YZ = 3'd1,
        REG_PROCESS_NOISE = 3'd2,
        REG_INIT_COV_X    = 3'd3,
        REG_INIT_COV_YZ   = 3'd4,
        REG_INIT_EST_X    = 3'd5,
        REG_INIT_EST_YZ   = 3'd6
    } cfg_idx_t;

    localparam int CFG_ADDR_W = 3;

    // reset values, integer part only (scaled by the fraction bits)
    localparam longint RST_MEAS_NOISE_X  = 4;
    localparam longint RST_MEAS_NOISE_YZ = 1;
    localparam longint RST_PROCESS_NOISE = 0;
    localparam longint RST_INIT_COV_X    = 6;
    localparam longint RST_INIT_COV_YZ   = 1;
    localparam longint RST_INIT_EST_X    = 14;
    localparam longint RST_INIT_EST_YZ   = 0;

endpackage

FILE: hw/rtl/scalar_kalman_filter_3ch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_3ch: three independent scalar kalman filters
// constant-state model, identity state and measurement matrices
// ----------------------------------------------------------------------------
// Each input word carries one measurement per channel (x, y, z, signed
// Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS) and yields one output word with the
// three new estimates. Per channel the filter predicts Pp = P + Q (saturated),
// forms the gain K = Pp / (Pp + R) (zero when the divisor is zero), updates
// the estimate by K times the innovation and scales Pp by (1 - K). Channels
// are processed one after another on a single restoring divider and a single
// shared multiplier under a small sequencer, so s_tready is high only while
// the block is idle. The divider produces one quotient bit per cycle and is
// skipped for a channel whose divisor is zero. s_tready rises in the same
// cycle as m_tvalid, when the sequencer returns from ST_FIN to ST_IDLE.
// The result sits in an output register, so the next word is accepted while
// the previous result still waits for m_tready. The first word after reset
// loads estimates and covariances from the init registers; later writes to
// the init registers have no effect, since reset also restores their
// defaults; noise registers take effect on the next word. Write
// configuration only while idle.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_3ch
    import skf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, from bit 0: meas_x, meas_y, meas_z, zero fill to whole bytes
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, from bit 0: est_x, est_y, est_z, zero fill to whole bytes
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [CFG_ADDR_W-1:0]             cfg_addr,
    input  logic [DATA_WIDTH-1:0]             cfg_wdata
);

    localparam int W       = DATA_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int TDATA_W = ((3*W+7)/8)*8;
    localparam int PROD_W  = W + F + 3;

    // register reset values in the fixed-point format
    localparam logic [W-2:0] RST_RX  = (W-1)'(RST_MEAS_NOISE_X  <<< F);
    localparam logic [W-2:0] RST_RYZ = (W-1)'(RST_MEAS_NOISE_YZ <<< F);
    localparam logic [W-2:0] RST_Q   = (W-1)'(RST_PROCESS_NOISE <<< F);
    localparam logic [W-2:0] RST_PX  = (W-1)'(RST_INIT_COV_X    <<< F);
    localparam logic [W-2:0] RST_PYZ = (W-1)'(RST_INIT_COV_YZ   <<< F);
    localparam logic [W-1:0] RST_EX  = W'(RST_INIT_EST_X  <<< F);
    localparam logic [W-1:0] RST_EYZ = W'(RST_INIT_EST_YZ <<< F);

    // gain of one
    localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DEN,
        ST_DIV,
        ST_MUL,
        ST_EST,
        ST_COV,
        ST_FIN
    } state_t;

    // configuration registers
    logic [W-2:0] rx_reg;
    logic [W-2:0] ryz_reg;
    logic [W-2:0] q_reg;
    logic [W-2:0] px_reg;
    logic [W-2:0] pyz_reg;
    logic [W-1:0] ex_reg;
    logic [W-1:0] eyz_reg;

    // filter state and working registers
    state_t              state_reg;
    logic [1:0]          ch_reg;
    logic                started_reg;
    logic signed [W-1:0] est_reg  [3];
    logic [W-2:0]        cov_reg  [3];
    logic signed [W-1:0] meas_reg [3];
    logic [W-2:0]        pp_reg;
    logic [F:0]          k_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                m_tvalid_reg;
    logic [TDATA_W-1:0]  m_tdata_reg;

    // datapath
    logic [W-2:0]             r_sel;
    logic [W-1:0]             pp_sum;
    logic [W-2:0]             pp_sat;
    logic [W-1:0]             den_sum;
    logic signed [W:0]        innov;
    logic signed [W:0]        mul_a;
    logic signed [F+1:0]      mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [W:0]        est_add;
    logic signed [W+1:0]      est_sum;
    logic signed [W-1:0]      est_sat;
    logic                     div_start;
    logic                     div_done;
    logic [F:0]               div_quot;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_reg  <= RST_RX;
            ryz_reg <= RST_RYZ;
            q_reg   <= RST_Q;
            px_reg  <= RST_PX;
            pyz_reg <= RST_PYZ;
            ex_reg  <= RST_EX;
            eyz_reg <= RST_EYZ;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_MEAS_NOISE_X:  rx_reg  <= cfg_wdata[W-2:0];
                REG_MEAS_NOISE_YZ: ryz_reg <= cfg_wdata[W-2:0];
                REG_PROCESS_NOISE: q_reg   <= cfg_wdata[W-2:0];
                REG_INIT_COV_X:    px_reg  <= cfg_wdata[W-2:0];
                REG_INIT_COV_YZ:   pyz_reg <= cfg_wdata[W-2:0];
                REG_INIT_EST_X:    ex_reg  <= cfg_wdata;
                REG_INIT_EST_YZ:   eyz_reg <= cfg_wdata;
                default:           ; // index beyond the list: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // per-channel arithmetic
    // ------------------------------------------------------------------
    // channel x has its own measurement noise, y and z share one
    assign r_sel = (ch_reg == 2'd0) ? rx_reg : ryz_reg;

    // predicted covariance, saturated to the unsigned covariance range
    assign pp_sum = {1'b0, cov_reg[ch_reg]} + {1'b0, q_reg};
    assign pp_sat = pp_sum[W-1] ? {(W-1){1'b1}} : pp_sum[W-2:0];

    // gain divisor; cannot overflow W bits
    assign den_sum = {1'b0, pp_reg} + {1'b0, r_sel};

    assign innov = {meas_reg[ch_reg][W-1], meas_reg[ch_reg]}
                 - {est_reg[ch_reg][W-1], est_reg[ch_reg]};

    // shared multiplier: innovation times gain, then covariance times (1 - gain)
    always_comb
    begin
        if (state_reg == ST_EST)
        begin
            mul_a = {2'b00, pp_reg};
            mul_b = {1'b0, ONE_Q - k_reg};
        end
        else
        begin
            mul_a = innov;
            mul_b = {1'b0, k_reg};
        end
    end

    assign prod_next = PROD_W'(mul_a * mul_b);

    // floor of the product over 2^F is the arithmetic shift
    assign est_add = prod_reg[F +: W+1];
    assign est_sum = {{2{est_reg[ch_reg][W-1]}}, est_reg[ch_reg]}
                   + {est_add[W], est_add};

    always_comb
    begin
        if (est_sum[W+1:W-1] == 3'b000 || est_sum[W+1:W-1] == 3'b111)
            est_sat = est_sum[W-1:0];
        else if (est_sum[W+1])
            est_sat = {1'b1, {(W-1){1'b0}}};
        else
            est_sat = {1'b0, {(W-1){1'b1}}};
    end

    assign div_start = (state_reg == ST_DEN) && (den_sum != '0);

    skf_gain_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (pp_reg),
        .den   (den_sum),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ch_reg       <= 2'd0;
            started_reg  <= 1'b0;
            est_reg      <= '{default: '0};
            cov_reg      <= '{default: '0};
            meas_reg     <= '{default: '0};
            pp_reg       <= '0;
            k_reg        <= '0;
            prod_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // ST_FIN refills the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        meas_reg[0] <= s_tdata[0*W +: W];
                        meas_reg[1] <= s_tdata[1*W +: W];
                        meas_reg[2] <= s_tdata[2*W +: W];
                        ch_reg      <= 2'd0;
                        // first word: load the initial state
                        if (!started_reg)
                        begin
                            started_reg <= 1'b1;
                            est_reg[0]  <= ex_reg;
                            est_reg[1]  <= eyz_reg;
                            est_reg[2]  <= eyz_reg;
                            cov_reg[0]  <= px_reg;
                            cov_reg[1]  <= pyz_reg;
                            cov_reg[2]  <= pyz_reg;
                        end
                        state_reg <= ST_PRED;
                    end
                end
                ST_PRED:
                begin
                    pp_reg    <= pp_sat;
                    state_reg <= ST_DEN;
                end
                ST_DEN:
                begin
                    // zero divisor: gain zero, state keeps its prediction
                    if (den_sum == '0)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        k_reg     <= div_quot;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_EST;
                end
                ST_EST:
                begin
                    est_reg[ch_reg] <= est_sat;
                    prod_reg        <= prod_next;
                    state_reg       <= ST_COV;
                end
                ST_COV:
                begin
                    cov_reg[ch_reg] <= prod_reg[F +: W-1];
                    if (ch_reg == 2'd2)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= ST_PRED;
                    end
                end
                ST_FIN:
                begin
                    // wait until the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= TDATA_W'({est_reg[2], est_reg[1], est_reg[0]});
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hw/rtl/skf_gain_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_gain_div: radix-2 restoring divider for the kalman gain
// quot = floor(num * 2^FRAC_BITS / den), num <= den, den nonzero,
// one quotient bit per cycle
// ----------------------------------------------------------------------------
module skf_gain_div
    import skf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-2:0] num,
    input  logic [DATA_WIDTH-1:0] den,
    output logic                  done,
    output logic [FRAC_BITS:0]    quot
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [FRAC_BITS:0]    quot_reg;

    logic [DATA_WIDTH-1:0] num_ext;
    logic                  first_ge;
    logic [DATA_WIDTH:0]   rem_shift;
    logic                  step_ge;
    logic [DATA_WIDTH:0]   rem_sub;

    assign num_ext   = {1'b0, num};
    assign first_ge  = (num_ext >= den);
    assign rem_shift = {rem_reg, 1'b0};
    assign step_ge   = (rem_shift >= {1'b0, den_reg});
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    assign done = busy_reg && (cnt_reg == '0);
    assign quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
        end
        else if (start)
        begin
            // integer bit: gain of exactly one when num equals den
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(FRAC_BITS);
            den_reg  <= den;
            rem_reg  <= first_ge ? (num_ext - den) : num_ext;
            quot_reg <= (FRAC_BITS + 1)'(first_ge);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                rem_reg  <= step_ge ? rem_sub[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
                quot_reg <= {quot_reg[FRAC_BITS-1:0], step_ge};
            end
        end
    end

endmodule
